// ===== src/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometry package
// Widths, constants, register map and shared types of the odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int SPEED_W = 16;
  localparam int MAG_W   = 17;
  localparam int MWS_W   = 15;
  localparam int GEOM_W  = 16;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 56;
  localparam int D24_W  = 36;

  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] CLIP_STEPS = DIV_CNT_W'(MWS_W);
  localparam logic [DIV_CNT_W-1:0] TURN_STEPS = DIV_CNT_W'(DIV_NUM_W);

  localparam int CORD_W = 33;
  localparam int TRIG_W = 19;
  localparam int ATAN_N = 24;
  localparam int ATAN_W = 30;
  localparam int ATAN_IDX_W = 5;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);
  localparam logic [CORD_W-1:0] HALF_TURN   = CORD_W'(64'h8000_0000);
  localparam logic [CORD_W-1:0] TRIG_ROUND  = CORD_W'(8192);
  localparam logic signed [HEAD_W-1:0] QUARTER_TURN = HEAD_W'(16384);

  localparam int INV_W = 30;
  localparam logic [INV_W-1:0] INV_TWO_PI = INV_W'(683565276);

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_TRACK  = 3'd1;
  localparam logic [2:0] REG_MAXSPD = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;

  localparam logic [GEOM_W-1:0] RADIUS_RST = GEOM_W'(4096);
  localparam logic [GEOM_W-1:0] TRACK_RST  = GEOM_W'(2048);
  localparam logic [MWS_W-1:0]  MAXSPD_RST = MWS_W'(2560);
  localparam logic [GEOM_W-1:0] STEP_RST   = GEOM_W'(655);

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_DEN_W-1:0] rem0;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  function automatic logic [ATAN_W-1:0] atan_turn(logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = ATAN_W'(536870912);
      5'd1:    v = ATAN_W'(316933406);
      5'd2:    v = ATAN_W'(167458907);
      5'd3:    v = ATAN_W'(85004756);
      5'd4:    v = ATAN_W'(42667331);
      5'd5:    v = ATAN_W'(21354465);
      5'd6:    v = ATAN_W'(10679838);
      5'd7:    v = ATAN_W'(5340245);
      5'd8:    v = ATAN_W'(2670163);
      5'd9:    v = ATAN_W'(1335087);
      5'd10:   v = ATAN_W'(667544);
      5'd11:   v = ATAN_W'(333772);
      5'd12:   v = ATAN_W'(166886);
      5'd13:   v = ATAN_W'(83443);
      5'd14:   v = ATAN_W'(41722);
      5'd15:   v = ATAN_W'(20861);
      5'd16:   v = ATAN_W'(10430);
      5'd17:   v = ATAN_W'(5215);
      5'd18:   v = ATAN_W'(2608);
      5'd19:   v = ATAN_W'(1304);
      5'd20:   v = ATAN_W'(652);
      5'd21:   v = ATAN_W'(326);
      5'd22:   v = ATAN_W'(163);
      5'd23:   v = ATAN_W'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/odo_in_if.sv =====
// ----------------------------------------------------------------------------
// Wheel speed channel
// Valid/ready channel carrying one pair of wheel angular speeds per beat.
// ----------------------------------------------------------------------------
interface odo_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [odo_pkg::SPEED_W-1:0] left_speed;
  logic signed [odo_pkg::SPEED_W-1:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

// ===== src/odo_out_if.sv =====
// ----------------------------------------------------------------------------
// Pose channel
// Valid/ready channel carrying one pose and the clip flag per beat.
// ----------------------------------------------------------------------------
interface odo_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [odo_pkg::POS_W-1:0]  pos_x;
  logic signed [odo_pkg::POS_W-1:0]  pos_y;
  logic signed [odo_pkg::HEAD_W-1:0] heading;
  logic                               clipped;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output clipped, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading,
                input clipped, output ready);
endinterface

// ===== src/odo_div.sv =====
// ----------------------------------------------------------------------------
// Odometry divider
// Restoring divider, one quotient bit per cycle, shared by the speed clip
// and the turn computation.
// ----------------------------------------------------------------------------
module odo_div (
  input  logic                              clk,
  input  logic                              rst,
  input  odo_pkg::div_req_t                 req,
  output logic                              busy,
  output logic [odo_pkg::DIV_NUM_W-1:0]     quo
);
  import odo_pkg::*;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] nq;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  always_comb begin
    trial    = {rem, nq[DIV_NUM_W-1]};
    qbit     = (trial >= {1'b0, den});
    rem_next = qbit ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
      rem  <= req.rem0;
      nq   <= req.num;
      den  <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      nq  <= {nq[DIV_NUM_W-2:0], qbit};
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = nq;

endmodule

// ===== src/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// Odometry CORDIC
// Iterative rotation giving cosine and sine of a binary angle in Q.16,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module odo_cordic #(
  parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [odo_pkg::HEAD_W-1:0]  angle,
  output odo_pkg::trig_t                      trig
);
  import odo_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [CORD_W-1:0] z;
  logic signed [CORD_W-1:0] z0;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [CORD_W-1:0] at;
  logic signed [CORD_W-1:0] xf;
  logic signed [CORD_W-1:0] yf;
  logic signed [CORD_W-1:0] xr;
  logic signed [CORD_W-1:0] yr;
  logic [IW-1:0]            i;
  logic                     busy;
  logic                     flip;
  logic                     fold_pos;
  logic                     fold_neg;

  always_comb begin
    z0       = $signed({{(CORD_W-HEAD_W-16){angle[HEAD_W-1]}}, angle, 16'b0});
    fold_pos = (angle > QUARTER_TURN);
    fold_neg = (angle < -QUARTER_TURN);
    if (fold_pos) begin
      z0 = z0 - $signed(HALF_TURN);
    end else if (fold_neg) begin
      z0 = z0 + $signed(HALF_TURN);
    end
    xs = x >>> i;
    ys = y >>> i;
    at = $signed({{(CORD_W-ATAN_W){1'b0}}, atan_turn(ATAN_IDX_W'(i))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      i    <= '0;
      x    <= $signed(CORDIC_GAIN);
      y    <= '0;
      z    <= z0;
      flip <= fold_pos | fold_neg;
    end else if (busy) begin
      if (!z[CORD_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      i <= i + IW'(1);
      if (i == IW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    xf = flip ? -x : x;
    yf = flip ? -y : y;
    xr = xf + $signed(TRIG_ROUND);
    yr = yf + $signed(TRIG_ROUND);
    trig.busy  = busy;
    trig.cos_v = xr[CORD_W-1 -: TRIG_W];
    trig.sin_v = yr[CORD_W-1 -: TRIG_W];
  end

endmodule

// ===== src/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose from wheel speeds: clip, speed and turn, CORDIC
// heading, saturating integration, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          beat
//  wheel    in   valid/ready        left_speed, right_speed
//  pose     out  valid/ready        pos_x, pos_y, heading, clipped
//  apb      in   psel/penable       5 registers at 4*i, pready tied high
//
//  The 48-step turn division in the shared divider sets the time from one
//  accepted beat to the next, and the clip division adds to it when the
//  speeds are clipped. With the wheels disabled a beat goes straight to done.
//  wheel.ready is high only when the sequencer is idle; a finished pose
//  waits in the output register while the next beat is taken.
//  rst is synchronous and returns pose and registers to their reset values.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [odo_pkg::ADDR_W-1:0]    paddr,
  input  logic [odo_pkg::DATA_W-1:0]    pwdata,
  output logic [odo_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  odo_in_if.sink                        wheel,
  odo_out_if.source                     pose
);
  import odo_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'd1,
    S_LOAD   = 18'd2,
    S_CDIV   = 18'd4,
    S_CWAIT  = 18'd8,
    S_MDIST  = 18'd16,
    S_MDISTT = 18'd32,
    S_MTURN  = 18'd64,
    S_MTURNT = 18'd128,
    S_HDIV   = 18'd256,
    S_HWAIT  = 18'd512,
    S_MXLO   = 18'd1024,
    S_MXHI   = 18'd2048,
    S_MYLO   = 18'd4096,
    S_MYHI   = 18'd8192,
    S_MHLO   = 18'd16384,
    S_MHHI   = 18'd32768,
    S_HUPD   = 18'd65536,
    S_DONE   = 18'd131072
  } state_t;

  state_t state;
  state_t state_next;

  logic [GEOM_W-1:0] wheel_radius;
  logic [GEOM_W-1:0] half_track;
  logic [MWS_W-1:0]  max_wheel_speed;
  logic [GEOM_W-1:0] time_step;
  logic              wheels_enabled;

  logic [2:0] reg_idx;
  logic       reg_wr;

  logic [SPEED_W-1:0] l_spd;
  logic [SPEED_W-1:0] r_spd;
  logic               clip_flag;
  logic               fast_left;
  logic [MAG_W-1:0]   m_hold;
  logic [D24_W-1:0]   d24;
  logic [ACC_W-1:0]   acc;
  logic [POS_W-1:0]   pose_x;
  logic [POS_W-1:0]   pose_y;
  logic [HEAD_W-1:0]  pose_heading;

  logic [POS_W-1:0]  out_x;
  logic [POS_W-1:0]  out_y;
  logic [HEAD_W-1:0] out_h;
  logic              out_clip;
  logic              out_valid;
  logic              out_load;
  logic              accept;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [MAG_W-1:0]   lx;
  logic [MAG_W-1:0]   rx;
  logic [MAG_W-1:0]   al;
  logic [MAG_W-1:0]   ar;
  logic               fast_l;
  logic [MAG_W-1:0]   mmax;
  logic [MAG_W-1:0]   mmin;
  logic               clip_now;
  logic [MAG_W-1:0]   spd_sum;
  logic [MAG_W-1:0]   spd_dif;
  logic [SPEED_W-1:0] absdif;
  logic               hneg;

  logic [MWS_W-1:0]   lmag;
  logic [MWS_W-1:0]   rmag;
  logic [SPEED_W-1:0] l_clip;
  logic [SPEED_W-1:0] r_clip;

  logic [ACC_W-1:0]  tot;
  logic [POS_W-1:0]  dpos;
  logic [POS_W:0]    psum;
  logic [POS_W-1:0]  psat;
  logic [POS_W-1:0]  pcur;
  logic [ACC_W-1:0]  hp;
  logic [ACC_W-1:0]  hn;
  logic [HEAD_W-1:0] dh;

  div_req_t              div_req;
  logic                  div_busy;
  logic [DIV_NUM_W-1:0]  div_quo;
  trig_t                 trig;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius    <= RADIUS_RST;
      half_track      <= TRACK_RST;
      max_wheel_speed <= MAXSPD_RST;
      time_step       <= STEP_RST;
      wheels_enabled  <= 1'b0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_RADIUS: wheel_radius    <= pwdata[GEOM_W-1:0];
        REG_TRACK:  half_track      <= pwdata[GEOM_W-1:0];
        REG_MAXSPD: max_wheel_speed <= pwdata[MWS_W-1:0];
        REG_STEP:   time_step       <= pwdata[GEOM_W-1:0];
        REG_ENABLE: wheels_enabled  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = {{(DATA_W-GEOM_W){1'b0}}, wheel_radius};
      REG_TRACK:  prdata = {{(DATA_W-GEOM_W){1'b0}}, half_track};
      REG_MAXSPD: prdata = {{(DATA_W-MWS_W){1'b0}}, max_wheel_speed};
      REG_STEP:   prdata = {{(DATA_W-GEOM_W){1'b0}}, time_step};
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, wheels_enabled};
      default:    prdata = '0;
    endcase
  end

  // Speed arithmetic
  always_comb begin
    lx       = {l_spd[SPEED_W-1], l_spd};
    rx       = {r_spd[SPEED_W-1], r_spd};
    al       = lx[MAG_W-1] ? (~lx + MAG_W'(1)) : lx;
    ar       = rx[MAG_W-1] ? (~rx + MAG_W'(1)) : rx;
    fast_l   = (al >= ar);
    mmax     = fast_l ? al : ar;
    mmin     = fast_l ? ar : al;
    clip_now = (mmax > {{(MAG_W-MWS_W){1'b0}}, max_wheel_speed});
    spd_sum  = lx + rx;
    spd_dif  = lx - rx;
    hneg     = spd_dif[MAG_W-1];
    absdif   = hneg ? SPEED_W'(~spd_dif + MAG_W'(1)) : spd_dif[SPEED_W-1:0];

    lmag   = fast_left ? max_wheel_speed : div_quo[MWS_W-1:0];
    rmag   = fast_left ? div_quo[MWS_W-1:0] : max_wheel_speed;
    l_clip = l_spd[SPEED_W-1] ? (~{1'b0, lmag} + SPEED_W'(1)) : {1'b0, lmag};
    r_clip = r_spd[SPEED_W-1] ? (~{1'b0, rmag} + SPEED_W'(1)) : {1'b0, rmag};
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOAD: begin
        mul_a = $signed({{(MUL_W-MAG_W){1'b0}}, mmin});
        mul_b = $signed({{(MUL_W-MWS_W){1'b0}}, max_wheel_speed});
      end
      S_MDIST: begin
        mul_a = $signed({{(MUL_W-GEOM_W){1'b0}}, wheel_radius});
        mul_b = $signed({{(MUL_W-MAG_W){spd_sum[MAG_W-1]}}, spd_sum});
      end
      S_MDISTT, S_MTURNT: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = $signed({{(MUL_W-GEOM_W){1'b0}}, time_step});
      end
      S_MTURN: begin
        mul_a = $signed({{(MUL_W-GEOM_W){1'b0}}, wheel_radius});
        mul_b = $signed({{(MUL_W-SPEED_W){1'b0}}, absdif});
      end
      S_MXLO: begin
        mul_a = $signed({{(MUL_W-18){1'b0}}, d24[17:0]});
        mul_b = $signed({{(MUL_W-TRIG_W){trig.cos_v[TRIG_W-1]}}, trig.cos_v});
      end
      S_MXHI: begin
        mul_a = $signed({{(MUL_W-(D24_W-18)){d24[D24_W-1]}}, d24[D24_W-1:18]});
        mul_b = $signed({{(MUL_W-TRIG_W){trig.cos_v[TRIG_W-1]}}, trig.cos_v});
      end
      S_MYLO: begin
        mul_a = $signed({{(MUL_W-18){1'b0}}, d24[17:0]});
        mul_b = $signed({{(MUL_W-TRIG_W){trig.sin_v[TRIG_W-1]}}, trig.sin_v});
      end
      S_MYHI: begin
        mul_a = $signed({{(MUL_W-(D24_W-18)){d24[D24_W-1]}}, d24[D24_W-1:18]});
        mul_b = $signed({{(MUL_W-TRIG_W){trig.sin_v[TRIG_W-1]}}, trig.sin_v});
      end
      S_MHLO: begin
        mul_a = $signed({{(MUL_W-24){1'b0}}, div_quo[23:0]});
        mul_b = $signed({{(MUL_W-INV_W){1'b0}}, INV_TWO_PI});
      end
      S_MHHI: begin
        mul_a = $signed({{(MUL_W-(DIV_NUM_W-24)){1'b0}}, div_quo[DIV_NUM_W-1:24]});
        mul_b = $signed({{(MUL_W-INV_W){1'b0}}, INV_TWO_PI});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state)
      S_CDIV: begin
        div_req.start = clip_flag;
        div_req.steps = CLIP_STEPS;
        div_req.rem0  = prod[MWS_W +: DIV_DEN_W];
        div_req.num   = {prod[MWS_W-1:0], {(DIV_NUM_W-MWS_W){1'b0}}};
        div_req.den   = m_hold;
      end
      S_HDIV: begin
        div_req.start = (half_track != '0);
        div_req.steps = TURN_STEPS;
        div_req.rem0  = '0;
        div_req.num   = prod[DIV_NUM_W-1:0];
        div_req.den   = {half_track, 1'b0};
      end
      default: ;
    endcase
  end

  odo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quo  (div_quo)
  );

  assign accept = wheel.valid & wheel.ready;

  odo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .angle ($signed(pose_heading)),
    .trig  (trig)
  );

  // Pose update
  always_comb begin
    tot  = acc + (prod[ACC_W-1:0] << 18);
    dpos = tot[ACC_W-1 -: POS_W];
    pcur = state[12] ? pose_x : pose_y;
    psum = {pcur[POS_W-1], pcur} + {dpos[POS_W-1], dpos};
    psat = (psum[POS_W] != psum[POS_W-1]) ? (psum[POS_W] ? POS_MIN : POS_MAX)
                                          : psum[POS_W-1:0];
    hp   = acc + (prod[ACC_W-1:0] << 24);
    hn   = hneg ? (~hp + ACC_W'(1)) : hp;
    dh   = (half_track == '0) ? '0 : hn[ACC_W-1 -: HEAD_W];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = wheels_enabled ? S_LOAD : S_DONE;
      S_LOAD:   state_next = S_CDIV;
      S_CDIV:   state_next = clip_flag ? S_CWAIT : S_MDIST;
      S_CWAIT:  if (!div_busy) state_next = S_MDIST;
      S_MDIST:  state_next = S_MDISTT;
      S_MDISTT: state_next = S_MTURN;
      S_MTURN:  state_next = S_MTURNT;
      S_MTURNT: state_next = S_HDIV;
      S_HDIV:   state_next = S_HWAIT;
      S_HWAIT:  if (!div_busy && !trig.busy) state_next = S_MXLO;
      S_MXLO:   state_next = S_MXHI;
      S_MXHI:   state_next = S_MYLO;
      S_MYLO:   state_next = S_MYHI;
      S_MYHI:   state_next = S_MHLO;
      S_MHLO:   state_next = S_MHHI;
      S_MHHI:   state_next = S_HUPD;
      S_HUPD:   state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      clip_flag    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            l_spd     <= wheel.left_speed;
            r_spd     <= wheel.right_speed;
            clip_flag <= 1'b0;
          end
        end
        S_LOAD: begin
          clip_flag <= clip_now;
          fast_left <= fast_l;
          m_hold    <= mmax;
        end
        S_CWAIT: begin
          if (!div_busy) begin
            l_spd <= l_clip;
            r_spd <= r_clip;
          end
        end
        S_MTURN: d24 <= prod[D24_W+12:13];
        S_MXHI, S_MYHI, S_MHHI: acc <= prod[ACC_W-1:0];
        S_MYLO: pose_x <= psat;
        S_MHLO: pose_y <= psat;
        S_HUPD: pose_heading <= pose_heading + dh;
        default: ;
      endcase
    end
  end

  // Output register
  assign out_load    = state[17] & (~out_valid | pose.ready);
  assign wheel.ready = state[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pose.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x    <= pose_x;
      out_y    <= pose_y;
      out_h    <= pose_heading;
      out_clip <= clip_flag;
    end
  end

  assign pose.valid   = out_valid;
  assign pose.pos_x   = $signed(out_x);
  assign pose.pos_y   = $signed(out_y);
  assign pose.heading = $signed(out_h);
  assign pose.clipped = out_clip;

endmodule

// ===== tb/diff_drive_odometry_tb.sv =====
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives wheel speed beats into the block and configures it over APB in
// phases. A pose predictor runs alongside: clipping, CORDIC cos/sin and the
// saturating integration. Every pose beat is checked field by field against
// the oldest prediction. Both channels idle at random, and the pose side
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import odo_pkg::*;

  localparam int CORDIC_ITERS  = 16;
  localparam int MAX_WAIT      = 5;
  localparam int LONG_HOLD_AT  = 200;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;

  localparam longint CORDIC_X0    = 652032874;
  localparam longint TURN_PER_RAD = 683565276;
  localparam longint POS_HI       = 64'sd2147483647;
  localparam longint POS_LO       = -64'sd2147483648;
  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
  } wheel_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HEAD_W-1:0]       heading;
    logic                    clipped;
  } pose_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  odo_in_if  wheel_if ();
  odo_out_if pose_if ();

  // register and pose copies held by the predictor
  logic [GEOM_W-1:0]       radius_r;
  logic [GEOM_W-1:0]       track_r;
  logic [MWS_W-1:0]        maxspd_r;
  logic [GEOM_W-1:0]       step_r;
  logic                    enable_r;
  logic signed [POS_W-1:0] pose_x_r;
  logic signed [POS_W-1:0] pose_y_r;
  logic [HEAD_W-1:0]       heading_r;

  wheel_beat_t wheel_q [$];
  pose_t       pose_expect_q [$];
  wheel_beat_t wheel_cur;

  int err_count   = 0;
  int poses_seen  = 0;
  int idle_cycles = 0;
  int wheel_wait  = 0;
  int pose_hold   = 0;
  bit steady      = 1'b0;

  diff_drive_odometry #(.CORDIC_STEPS(CORDIC_ITERS)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wheel   (wheel_if),
    .pose    (pose_if)
  );

  always #4 clk = ~clk;

  function automatic int draw_wait();
    return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(longint v);
    if (v > POS_HI) return POS_W'(POS_HI);
    if (v < POS_LO) return POS_W'(POS_LO);
    return POS_W'(v);
  endfunction

  function automatic void trig_of(input logic signed [HEAD_W-1:0] h,
                                  output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip;
    x = CORDIC_X0;
    y = 0;
    z = longint'(h) * 65536;
    flip = 1'b0;
    // fold into the right half-plane
    if (h > 16384) begin
      z = z - (longint'(1) << 31);
      flip = 1'b1;
    end else if (h < -16384) begin
      z = z + (longint'(1) << 31);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURNS[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endfunction

  function automatic void advance_pose(input wheel_beat_t b);
    longint            l, r, al, ar, m, rad, trk, stp, lim;
    longint            d24, c, s, q;
    logic [63:0]       turn;
    logic [HEAD_W-1:0] dh;
    pose_t             res;
    res.clipped = 1'b0;
    if (enable_r) begin
      l   = b.left;
      r   = b.right;
      rad = radius_r;
      trk = track_r;
      stp = step_r;
      lim = maxspd_r;
      al  = (l < 0) ? -l : l;
      ar  = (r < 0) ? -r : r;
      m   = (al > ar) ? al : ar;
      if (m > lim) begin
        l = (l < 0) ? -(al * lim / m) : al * lim / m;
        r = (r < 0) ? -(ar * lim / m) : ar * lim / m;
        res.clipped = 1'b1;
      end
      d24 = (rad * (l + r) * stp) >>> 13;
      trig_of(heading_r, c, s);
      pose_x_r = sat_pos(longint'(pose_x_r) + ((d24 * c) >>> 24));
      pose_y_r = sat_pos(longint'(pose_y_r) + ((d24 * s) >>> 24));
      dh = '0;
      if (trk != 0) begin
        q    = rad * (l - r) * stp / (2 * trk);
        turn = q * TURN_PER_RAD;
        dh   = turn[55:40];
      end
      heading_r = heading_r + dh;
    end
    res.x       = pose_x_r;
    res.y       = pose_y_r;
    res.heading = heading_r;
    pose_expect_q = {pose_expect_q, res};
  endfunction

  function automatic void send(int l, int r);
    wheel_beat_t b;
    b.left  = SPEED_W'(l);
    b.right = SPEED_W'(r);
    wheel_q = {wheel_q, b};
  endfunction

  function automatic logic [SPEED_W-1:0] corner_speed(int lim);
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hffff;
      3:       return '0;
      4:       return 16'h0001;
      5:       return 16'h7fff;
      6:       return SPEED_W'(lim);
      default: return SPEED_W'(-lim - 1);
    endcase
  endfunction

  function automatic wheel_beat_t draw_speeds(int lim);
    wheel_beat_t b;
    int          a;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        b.left  = SPEED_W'($urandom);
        b.right = SPEED_W'($urandom);
      end
      3, 4: begin
        b.left  = SPEED_W'($urandom_range(0, 2 * lim) - lim);
        b.right = SPEED_W'($urandom_range(0, 2 * lim) - lim);
      end
      5: begin
        a = $urandom_range(0, 2 * lim) - lim;
        b.left  = SPEED_W'(a);
        b.right = SPEED_W'(a);
      end
      6: begin
        b.left  = corner_speed(lim);
        b.right = corner_speed(lim);
      end
      default: begin
        b.left  = SPEED_W'($urandom_range(0, 511) - 256);
        b.right = SPEED_W'($urandom_range(0, 511) - 256);
      end
    endcase
    return b;
  endfunction

  function automatic int draw_geom();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 15);
      1:       return 65535;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input int value, input int width);
    logic [DATA_W-1:0] data;
    data = DATA_W'(value);
    // junk above the register width must be dropped
    if (width < DATA_W && $urandom_range(0, 3) == 0)
      data = data | (DATA_W'($urandom) << width);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RADIUS: radius_r = data[GEOM_W-1:0];
      REG_TRACK:  track_r  = data[GEOM_W-1:0];
      REG_MAXSPD: maxspd_r = data[MWS_W-1:0];
      REG_STEP:   step_r   = data[GEOM_W-1:0];
      REG_ENABLE: enable_r = data[0];
      default: ;
    endcase
  endtask

  task automatic setup(input int rad, input int trk, input int lim, input int stp,
                       input int en);
    write_reg(REG_RADIUS, rad, GEOM_W);
    write_reg(REG_TRACK, trk, GEOM_W);
    write_reg(REG_MAXSPD, lim, MWS_W);
    write_reg(REG_STEP, stp, GEOM_W);
    write_reg(REG_ENABLE, en, 1);
  endtask

  task automatic drain();
    while (wheel_q.size() != 0 || wheel_if.valid || pose_expect_q.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : wheel_drive
    if (rst) begin
      wheel_if.valid <= 1'b0;
      wheel_wait     <= 0;
    end else begin
      if (wheel_if.valid && wheel_if.ready)
        advance_pose(wheel_cur);
      if (!wheel_if.valid || wheel_if.ready) begin
        if (wheel_wait != 0) begin
          wheel_if.valid <= 1'b0;
          wheel_wait     <= wheel_wait - 1;
        end else if (wheel_q.size() != 0) begin
          wheel_cur = wheel_q.pop_front();
          wheel_if.valid       <= 1'b1;
          wheel_if.left_speed  <= wheel_cur.left;
          wheel_if.right_speed <= wheel_cur.right;
          wheel_wait           <= draw_wait();
        end else begin
          wheel_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : pose_watch
    pose_t want;
    int    hold;
    if (rst) begin
      pose_if.ready <= 1'b0;
      pose_hold     <= 0;
    end else if (pose_if.valid && pose_if.ready) begin
      if (pose_expect_q.size() == 0) begin
        $error("pose beat with no prediction pending");
        err_count++;
      end else begin
        want = pose_expect_q.pop_front();
        if (pose_if.pos_x !== want.x) begin
          $error("pos_x: expected %0d, got %0d", want.x, pose_if.pos_x);
          err_count++;
        end
        if (pose_if.pos_y !== want.y) begin
          $error("pos_y: expected %0d, got %0d", want.y, pose_if.pos_y);
          err_count++;
        end
        if (pose_if.heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", $signed(want.heading),
                 pose_if.heading);
          err_count++;
        end
        if (pose_if.clipped !== want.clipped) begin
          $error("clipped: expected %0d, got %0d", want.clipped, pose_if.clipped);
          err_count++;
        end
      end
      poses_seen++;
      // hold off long once so the input side backs up
      hold = (poses_seen == LONG_HOLD_AT) ? LONG_HOLD : draw_wait();
      pose_if.ready <= (hold == 0);
      pose_hold     <= (hold == 0) ? 0 : hold - 1;
    end else if (!pose_if.ready) begin
      if (pose_hold == 0) pose_if.ready <= 1'b1;
      else pose_hold <= pose_hold - 1;
    end
  end

  always @(posedge clk) begin : stall_watch
    if (rst || psel || (wheel_if.valid && wheel_if.ready) ||
        (pose_if.valid && pose_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int rad, trk, lim, stp, en, count;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    wheel_if.valid       = 1'b0;
    wheel_if.left_speed  = '0;
    wheel_if.right_speed = '0;
    pose_if.ready        = 1'b0;
    radius_r             = RADIUS_RST;
    track_r              = TRACK_RST;
    maxspd_r             = MAXSPD_RST;
    step_r               = STEP_RST;
    enable_r             = 1'b0;
    pose_x_r             = '0;
    pose_y_r             = '0;
    heading_r            = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // wheels off: pose holds at zero
    @(negedge clk);
    send(32767, -32768);
    send(-1, 1);
    drain();
    setup(RADIUS_RST, TRACK_RST, MAXSPD_RST, STEP_RST, 1);
    @(negedge clk);
    send(0, 0);
    send(32767, 32767);
    send(-32768, -32768);
    send(32767, -32768);
    send(-32768, 32767);
    send(2560, 2560);
    send(2561, -7);
    send(-1, 1);
    send(300, -200);
    // zero speed limit and zero track
    drain();
    setup(65535, 0, 0, 65535, 1);
    @(negedge clk);
    send(5, -3);
    send(0, 0);
    send(-32768, 1);
    drain();
    setup(65535, 1, 32767, 65535, 1);
    @(negedge clk);
    send(32767, -32768);
    send(32767, 32767);
    send(32767, 32767);
    send(32767, 32767);
    send(-32768, -32768);
    // unmapped registers: writes must be dropped
    drain();
    for (int i = REG_ENABLE + 1; i < 8; i++)
      write_reg(3'(i), $urandom, DATA_W);
    @(negedge clk);
    send(1000, -1000);
    send(-500, 700);
    drain();
    setup(1, 1, 1, 1, 1);
    @(negedge clk);
    send(1, 0);
    send(-32768, 32767);
    send(1, 1);

    for (int p = 0; p < 10; p++) begin
      drain();
      rad   = draw_geom();
      trk   = draw_geom();
      stp   = draw_geom();
      lim   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(1, 32767);
      en    = 1;
      count = 124;
      case (p)
        0: begin rad = 65535; trk = 65535; lim = 32767; stp = 65535; end
        1: begin rad = 1; trk = 1; lim = 1; stp = 1; end
        2: begin rad = 65535; trk = 1; lim = 32767; stp = 65535; end
        7: begin en = 0; count = 20; end
        default: ;
      endcase
      steady = (p == 4);
      setup(rad, trk, lim, stp, en);
      @(negedge clk);
      repeat (count) wheel_q = {wheel_q, draw_speeds(lim)};
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== diff_drive_odometry.f =====
src/odo_pkg.sv
src/odo_in_if.sv
src/odo_out_if.sv
src/odo_div.sv
src/odo_cordic.sv
src/diff_drive_odometry.sv
tb/diff_drive_odometry_tb.sv
